// ===== hdl/assert_macros.svh =====
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the antecedent is followed by the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccsp_pkg.sv =====
package ccsp_pkg;

    localparam int unsigned VALUE_MAX_DEF = 255;
    localparam int unsigned TIME_MAX_DEF  = 65535;

    localparam int NFIELDS  = 5;
    localparam int NCHAN    = 4;
    localparam int FIELD_W  = 3;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 8;
    localparam int CHAN_OUT_W = 8;
    localparam int TIME_OUT_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Field order: red, green, blue, white, fade time
    localparam logic [FIELD_W-1:0] FLD_RED   = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_GREEN = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_BLUE  = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_WHITE = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_TIME  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_WHITE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_TIME  = 3'd4;

    localparam logic [CHAR_W-1:0] CODE_RED_RST   = 8'd114;
    localparam logic [CHAR_W-1:0] CODE_GREEN_RST = 8'd103;
    localparam logic [CHAR_W-1:0] CODE_BLUE_RST  = 8'd98;
    localparam logic [CHAR_W-1:0] CODE_WHITE_RST = 8'd119;
    localparam logic [CHAR_W-1:0] CODE_TIME_RST  = 8'd116;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    typedef enum logic [3:0] {
        PH_LETTER = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_FAIL   = 4'b1000
    } phase_t;

endpackage

// ===== hdl/ccsp_acc.sv =====
module ccsp_acc #(
    parameter int unsigned MAX = ccsp_pkg::VALUE_MAX_DEF
) (
    input  logic [$clog2(64'(MAX) + 64'd1)-1:0] acc_val,
    input  logic [ccsp_pkg::DIGIT_W-1:0]        digit,
    output logic [$clog2(64'(MAX) + 64'd1)-1:0] next_val,
    output logic                                fits
);

    localparam int W  = $clog2(64'(MAX) + 64'd1);
    localparam int PW = W + ccsp_pkg::DIGIT_W;

    logic [PW-1:0] prod;

    // acc*10 + digit as two shifts and two adds, then range check
    always_comb
    begin
        prod     = (PW'(acc_val) << 3) + (PW'(acc_val) << 1) + PW'(digit);
        fits     = (prod <= PW'(64'(MAX)));
        next_val = fits ? prod[W-1:0] : '0;
    end

endmodule

// ===== hdl/color_command_string_parser.sv =====
// A zero character in the input register loads its record into the result register, which drives out_valid.
// Throughput: one character per cycle, but a zero character waits while the result slot is
// full and not taken; combinational accumulate logic sits between input register and parse state.
// Reset (rst_n low, asynchronous): parse state clears, field codes return to their
// defaults, input and output registers empty.
module color_command_string_parser #(
    parameter int unsigned VALUE_MAX = ccsp_pkg::VALUE_MAX_DEF,
    parameter int unsigned TIME_MAX  = ccsp_pkg::TIME_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // character requests
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ccsp_pkg::CHAR_W-1:0]       char_in,
    // result requests
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic [ccsp_pkg::CHAN_OUT_W-1:0]   red,
    output logic [ccsp_pkg::CHAN_OUT_W-1:0]   green,
    output logic [ccsp_pkg::CHAN_OUT_W-1:0]   blue,
    output logic [ccsp_pkg::CHAN_OUT_W-1:0]   white,
    output logic [ccsp_pkg::TIME_OUT_W-1:0]   fade_time,
    // configuration write requests
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccsp_pkg::CHAR_W-1:0]       cfg_data
);

`include "assert_macros.svh"

    localparam int VAL_W  = $clog2(64'(VALUE_MAX) + 64'd1);
    localparam int TIME_W = $clog2(64'(TIME_MAX) + 64'd1);

    // ------------------------------------------------------------------
    // Field code registers
    // ------------------------------------------------------------------
    logic [ccsp_pkg::CHAR_W-1:0] code_reg [ccsp_pkg::NFIELDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg[0] <= ccsp_pkg::CODE_RED_RST;
            code_reg[1] <= ccsp_pkg::CODE_GREEN_RST;
            code_reg[2] <= ccsp_pkg::CODE_BLUE_RST;
            code_reg[3] <= ccsp_pkg::CODE_WHITE_RST;
            code_reg[4] <= ccsp_pkg::CODE_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes beyond the register list drop silently
            case (cfg_index)
                ccsp_pkg::REG_CODE_RED:   code_reg[0] <= cfg_data;
                ccsp_pkg::REG_CODE_GREEN: code_reg[1] <= cfg_data;
                ccsp_pkg::REG_CODE_BLUE:  code_reg[2] <= cfg_data;
                ccsp_pkg::REG_CODE_WHITE: code_reg[3] <= cfg_data;
                ccsp_pkg::REG_CODE_TIME:  code_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one character for the parse stage
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic [ccsp_pkg::CHAR_W-1:0] char_reg;
    logic                        is_nul;
    logic                        advance;
    logic                        step;
    logic                        out_valid_reg;

    assign is_nul = (char_reg == ccsp_pkg::CHAR_NUL);
    // A zero character needs a free result slot; anything else always moves on
    assign advance  = !(is_nul && out_valid_reg && !out_ready);
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    ccsp_pkg::phase_t               phase_reg, phase_next;
    logic [ccsp_pkg::FIELD_W-1:0]   field_reg, field_next;
    logic [VAL_W-1:0]               chan_acc_reg [ccsp_pkg::NCHAN];
    logic [VAL_W-1:0]               chan_acc_next [ccsp_pkg::NCHAN];
    logic [TIME_W-1:0]              time_acc_reg, time_acc_next;

    // One accumulate lane per field; only the current field's result is used
    logic [VAL_W-1:0]               chan_step [ccsp_pkg::NCHAN];
    logic [TIME_W-1:0]              time_step;
    logic [ccsp_pkg::NFIELDS-1:0]   fits_vec;
    logic [ccsp_pkg::DIGIT_W-1:0]   digit;
    logic                           is_digit;

    // '0'..'9' carry their value in the low nibble
    assign digit = char_reg[ccsp_pkg::DIGIT_W-1:0];

    for (genvar i = 0; i < ccsp_pkg::NCHAN; i++)
    begin : g_chan
        ccsp_acc #(
            .MAX (VALUE_MAX)
        ) u_acc (
            .acc_val  (chan_acc_reg[i]),
            .digit    (digit),
            .next_val (chan_step[i]),
            .fits     (fits_vec[i])
        );
    end

    ccsp_acc #(
        .MAX (TIME_MAX)
    ) u_time_acc (
        .acc_val  (time_acc_reg),
        .digit    (digit),
        .next_val (time_step),
        .fits     (fits_vec[ccsp_pkg::NFIELDS-1])
    );

    // Letter match: scan from the last field down so the first match wins
    logic                         hit_any;
    logic [ccsp_pkg::FIELD_W-1:0] hit_idx;
    logic                         take_letter;
    logic                         take_digit;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = ccsp_pkg::NFIELDS - 1; i >= 0; i--)
        begin
            if (code_reg[i] == char_reg)
            begin
                hit_any = 1'b1;
                hit_idx = ccsp_pkg::FIELD_W'(i);
            end
        end
    end

    always_comb
    begin
        is_digit = char_reg inside {[ccsp_pkg::CHAR_ZERO:ccsp_pkg::CHAR_NINE]};

        phase_next    = phase_reg;
        field_next    = field_reg;
        chan_acc_next = chan_acc_reg;
        time_acc_next = time_acc_reg;
        take_letter   = 1'b0;
        take_digit    = 1'b0;

        if (step && !is_nul)
        begin
            case (phase_reg)
                ccsp_pkg::PH_LETTER:
                begin
                    take_letter = 1'b1;
                end
                ccsp_pkg::PH_FIRST:
                begin
                    if (is_digit)
                    begin
                        take_digit = 1'b1;
                    end
                    else
                    begin
                        phase_next = ccsp_pkg::PH_FAIL;
                    end
                end
                ccsp_pkg::PH_DIGITS:
                begin
                    // A digit extends the value; anything else opens the next field
                    take_digit  = is_digit;
                    take_letter = !is_digit;
                end
                default: ; // failed: ignore everything up to the zero byte
            endcase
        end

        if (take_letter)
        begin
            if (hit_any)
            begin
                field_next = hit_idx;
                phase_next = ccsp_pkg::PH_FIRST;
                for (int i = 0; i < ccsp_pkg::NCHAN; i++)
                begin
                    if (hit_idx == ccsp_pkg::FIELD_W'(i))
                    begin
                        chan_acc_next[i] = '0;
                    end
                end
                if (hit_idx == ccsp_pkg::FLD_TIME)
                begin
                    time_acc_next = '0;
                end
            end
            else
            begin
                phase_next = ccsp_pkg::PH_FAIL;
            end
        end

        if (take_digit)
        begin
            // On overflow the lane already yields zero
            phase_next = fits_vec[field_reg] ? ccsp_pkg::PH_DIGITS : ccsp_pkg::PH_FAIL;
            for (int i = 0; i < ccsp_pkg::NCHAN; i++)
            begin
                if (field_reg == ccsp_pkg::FIELD_W'(i))
                begin
                    chan_acc_next[i] = chan_step[i];
                end
            end
            if (field_reg == ccsp_pkg::FLD_TIME)
            begin
                time_acc_next = time_step;
            end
        end

        // End of message: clear everything for the next one
        if (step && is_nul)
        begin
            phase_next    = ccsp_pkg::PH_LETTER;
            field_next    = ccsp_pkg::FLD_RED;
            time_acc_next = '0;
            for (int i = 0; i < ccsp_pkg::NCHAN; i++)
            begin
                chan_acc_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ccsp_pkg::PH_LETTER;
            field_reg    <= ccsp_pkg::FLD_RED;
            time_acc_reg <= '0;
            for (int i = 0; i < ccsp_pkg::NCHAN; i++)
            begin
                chan_acc_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            field_reg    <= field_next;
            time_acc_reg <= time_acc_next;
            chan_acc_reg <= chan_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                               out_valid_next;
    logic                               ok_reg;
    logic [ccsp_pkg::CHAN_OUT_W-1:0]    red_reg, green_reg, blue_reg, white_reg;
    logic [ccsp_pkg::TIME_OUT_W-1:0]    fade_time_reg;
    logic                               load_result;

    assign load_result = step && is_nul;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Outputs carry the low bits of each accumulator
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            ok_reg        <= (phase_reg == ccsp_pkg::PH_LETTER) ||
                             (phase_reg == ccsp_pkg::PH_DIGITS);
            red_reg       <= ccsp_pkg::CHAN_OUT_W'(chan_acc_reg[0]);
            green_reg     <= ccsp_pkg::CHAN_OUT_W'(chan_acc_reg[1]);
            blue_reg      <= ccsp_pkg::CHAN_OUT_W'(chan_acc_reg[2]);
            white_reg     <= ccsp_pkg::CHAN_OUT_W'(chan_acc_reg[3]);
            fade_time_reg <= ccsp_pkg::TIME_OUT_W'(time_acc_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign white     = white_reg;
    assign fade_time = fade_time_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_clear_after_nul, clk, rst_n, load_result,
        (phase_reg == ccsp_pkg::PH_LETTER) && (time_acc_reg == '0) && (field_reg == '0),
        "parse state not cleared after end of message")

    `ASSERT_NEXT(a_fail_gives_not_ok, clk, rst_n,
        load_result && ((phase_reg == ccsp_pkg::PH_FIRST) || (phase_reg == ccsp_pkg::PH_FAIL)),
        out_valid_reg && !ok_reg,
        "failed parse produced an ok record")

    `ASSERT_NEXT(a_drain_result, clk, rst_n,
        out_valid_reg && out_ready && !load_result, !out_valid_reg,
        "taken result still shown")

    `ASSERT_NEXT(a_hold_stalled_nul, clk, rst_n,
        in_valid_reg && is_nul && out_valid_reg && !out_ready,
        in_valid_reg && out_valid_reg && $stable(char_reg),
        "stalled end of message lost")

    `ASSERT_ALWAYS(a_time_in_range, clk, rst_n,
        64'(time_acc_reg) <= 64'(TIME_MAX),
        "fade time accumulator above its maximum")

endmodule
